/* src/shtc_pkg.sv */
// shared types, widths and codes for the surface height trace chunker
// no dependencies; every other file imports this package
package shtc_pkg;

    localparam int PIXEL_W    = 32;
    localparam int HEIGHT_W   = 13;
    localparam int ROW_W      = 12;
    localparam int SUM_W      = 21;
    localparam int CHUNK_W    = 9;
    localparam int MODE_W     = 2;
    localparam int DIV_CNT_W  = $clog2(SUM_W);
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 2;

    localparam logic [HEIGHT_W-1:0] MAX_HEIGHT = HEIGHT_W'(4096);
    localparam logic [CHUNK_W-1:0]  MAX_CHUNK  = CHUNK_W'(256);

    localparam logic [MODE_W-1:0] MODE_MEAN = 2'd0;
    localparam logic [MODE_W-1:0] MODE_HIGH = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOW  = 2'd2;

    localparam logic [REG_IDX_W-1:0] REG_CHUNK_SIZE   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_REDUCE_MODE  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_CLEAR_COLOUR = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd3;

    typedef struct packed {
        logic [CHUNK_W-1:0]  chunk_size;
        logic [MODE_W-1:0]   reduce_mode;
        logic [PIXEL_W-1:0]  clear_colour;
        logic [HEIGHT_W-1:0] image_height;
    } cfg_t;

    typedef struct packed {
        logic step;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic emit;
        logic mean;
        logic div_done;
        logic div_busy;
    } dp_status_t;

endpackage

/* src/shtc_if.sv */
// valid/ready channel interfaces for pixel requests and chunk results
// depends on shtc_pkg
interface shtc_pix_if;
    import shtc_pkg::*;

    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel_colour;
    logic               image_end;

    modport source (output valid, output pixel_colour, output image_end, input ready);
    modport sink   (input valid, input pixel_colour, input image_end, output ready);
endinterface

interface shtc_chunk_if;
    import shtc_pkg::*;

    logic                valid;
    logic                ready;
    logic [HEIGHT_W-1:0] chunk_height;
    logic                last_chunk;

    modport source (output valid, output chunk_height, output last_chunk, input ready);
    modport sink   (input valid, input chunk_height, input last_chunk, output ready);
endinterface

/* src/shtc_div.sv */
// bit-serial restoring divider, one quotient bit per cycle
// depends on shtc_pkg
module shtc_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [shtc_pkg::SUM_W-1:0]   dividend,
    input  logic [shtc_pkg::CHUNK_W-1:0] divisor,
    output logic                         busy,
    output logic                         done,
    output logic [shtc_pkg::SUM_W-1:0]   quotient
);
    import shtc_pkg::*;

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [SUM_W-1:0]     quo_reg, quo_next;
    logic [CHUNK_W-1:0]   rem_reg, rem_next;
    logic [CHUNK_W-1:0]   div_reg, div_next;
    logic [CHUNK_W:0]     rem_shift;
    logic                 fits;

    assign rem_shift = {rem_reg, quo_reg[SUM_W-1]};
    assign fits      = rem_shift >= {1'b0, div_reg};
    assign done      = busy_reg && (cnt_reg == DIV_CNT_W'(SUM_W - 1));

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? CHUNK_W'(rem_shift - {1'b0, div_reg}) : CHUNK_W'(rem_shift);
            quo_next = {quo_reg[SUM_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (done)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;
endmodule

/* src/shtc_datapath.sv */
// column trace, chunk accumulation, result staging and output register
// depends on shtc_pkg and shtc_div
module shtc_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  shtc_pkg::cfg_t                cfg,
    input  shtc_pkg::ctrl_cmd_t           cmd,
    input  logic [shtc_pkg::PIXEL_W-1:0]  pixel_colour,
    input  logic                          image_end,
    output shtc_pkg::dp_status_t          status,
    output logic [shtc_pkg::HEIGHT_W-1:0] chunk_height,
    output logic                          last_chunk
);
    import shtc_pkg::*;

    // trace state
    logic [HEIGHT_W-1:0] traced_reg, traced_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [ROW_W-1:0]    fca_reg, fca_next;
    logic [ROW_W-1:0]    crb_reg, crb_next;
    logic                prev_clr_reg, prev_clr_next;
    logic                found_reg, found_next;

    // chunk state
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [HEIGHT_W-1:0] high_reg, high_next;
    logic [HEIGHT_W-1:0] low_reg, low_next;
    logic [CHUNK_W-1:0]  cnt_reg, cnt_next;

    // staged result and output
    logic [HEIGHT_W-1:0] pend_value_reg;
    logic                pend_mean_reg;
    logic                pend_last_reg;
    logic [HEIGHT_W-1:0] out_height_reg;
    logic                out_last_reg;

    logic [HEIGHT_W-1:0] hgt;
    logic [CHUNK_W-1:0]  cs;
    logic                clr;
    logic [HEIGHT_W-1:0] row_ext;
    logic [HEIGHT_W-1:0] row_inc;
    logic [ROW_W-1:0]    crb_cur;
    logic [ROW_W-1:0]    fca_cur;
    logic                found_cur;
    logic                col_end;
    logic [HEIGHT_W-1:0] colh_raw;
    logic [HEIGHT_W-1:0] colh;
    logic [SUM_W-1:0]    sum_add;
    logic [HEIGHT_W-1:0] high_cur;
    logic [HEIGHT_W-1:0] low_cur;
    logic [CHUNK_W-1:0]  cnt_inc;
    logic                emit;
    logic                is_mean;
    logic [HEIGHT_W-1:0] direct_value;
    logic                div_start;
    logic                div_busy;
    logic                div_done;
    logic [SUM_W-1:0]    quotient;

    assign hgt = (cfg.image_height == '0) ? HEIGHT_W'(1) :
                 (cfg.image_height > MAX_HEIGHT) ? MAX_HEIGHT : cfg.image_height;
    assign cs  = (cfg.chunk_size == '0) ? CHUNK_W'(1) :
                 (cfg.chunk_size > MAX_CHUNK) ? MAX_CHUNK : cfg.chunk_size;

    assign clr     = pixel_colour == cfg.clear_colour;
    assign row_ext = {1'b0, row_reg};
    assign row_inc = row_ext + 1'b1;
    assign col_end = image_end || !(row_inc < hgt);

    // bottom of the clear run holding this row
    assign crb_cur = (clr && ((row_reg == '0) || !prev_clr_reg)) ? row_reg : crb_reg;

    always_comb
    begin
        fca_cur   = fca_reg;
        found_cur = found_reg;
        if (!found_reg)
        begin
            if (row_ext == traced_reg)
            begin
                if (clr)
                begin
                    fca_cur   = crb_cur;
                    found_cur = 1'b1;
                end
            end
            else if ((row_ext > traced_reg) && clr)
            begin
                fca_cur   = row_reg;
                found_cur = 1'b1;
            end
        end
    end

    assign colh_raw = found_cur ? {1'b0, fca_cur} : hgt;
    assign colh     = (colh_raw > hgt) ? hgt : colh_raw;
    assign sum_add  = sum_reg + SUM_W'(colh);
    assign high_cur = (colh > high_reg) ? colh : high_reg;
    assign low_cur  = (colh < low_reg) ? colh : low_reg;
    assign cnt_inc  = cnt_reg + 1'b1;
    assign emit     = col_end && (image_end || !(cnt_inc < cs));
    assign is_mean  = cfg.reduce_mode == MODE_MEAN;

    always_comb
    begin
        case (cfg.reduce_mode)
            MODE_HIGH: direct_value = high_cur;
            MODE_LOW:  direct_value = low_cur;
            default:   direct_value = '0;
        endcase
    end

    assign div_start = cmd.step && emit && is_mean;

    shtc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_add),
        .divisor  (cs),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        traced_next   = traced_reg;
        row_next      = row_reg;
        fca_next      = fca_reg;
        crb_next      = crb_reg;
        prev_clr_next = prev_clr_reg;
        found_next    = found_reg;
        sum_next      = sum_reg;
        high_next     = high_reg;
        low_next      = low_reg;
        cnt_next      = cnt_reg;
        if (cmd.step)
        begin
            if (!col_end)
            begin
                row_next      = ROW_W'(row_inc);
                fca_next      = fca_cur;
                crb_next      = crb_cur;
                prev_clr_next = clr;
                found_next    = found_cur;
            end
            else
            begin
                traced_next   = image_end ? '0 : colh;
                row_next      = '0;
                crb_next      = '0;
                prev_clr_next = 1'b0;
                found_next    = 1'b0;
                if (emit)
                begin
                    sum_next  = '0;
                    high_next = '0;
                    low_next  = '1;
                    cnt_next  = '0;
                end
                else
                begin
                    sum_next  = sum_add;
                    high_next = high_cur;
                    low_next  = low_cur;
                    cnt_next  = cnt_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            traced_reg   <= '0;
            row_reg      <= '0;
            fca_reg      <= '0;
            crb_reg      <= '0;
            prev_clr_reg <= 1'b0;
            found_reg    <= 1'b0;
            sum_reg      <= '0;
            high_reg     <= '0;
            low_reg      <= '1;
            cnt_reg      <= '0;
        end
        else
        begin
            traced_reg   <= traced_next;
            row_reg      <= row_next;
            fca_reg      <= fca_next;
            crb_reg      <= crb_next;
            prev_clr_reg <= prev_clr_next;
            found_reg    <= found_next;
            sum_reg      <= sum_next;
            high_reg     <= high_next;
            low_reg      <= low_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step && emit)
        begin
            pend_value_reg <= direct_value;
            pend_mean_reg  <= is_mean;
            pend_last_reg  <= image_end;
        end
        if (cmd.load_out)
        begin
            out_height_reg <= pend_mean_reg ? quotient[HEIGHT_W-1:0] : pend_value_reg;
            out_last_reg   <= pend_last_reg;
        end
    end

    assign status.emit     = emit;
    assign status.mean     = is_mean;
    assign status.div_done = div_done;
    assign status.div_busy = div_busy;
    assign chunk_height    = out_height_reg;
    assign last_chunk      = out_last_reg;
endmodule

/* src/shtc_ctrl.sv */
// controller: pixel acceptance, divide wait and output register handoff
// depends on shtc_pkg
module shtc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  shtc_pkg::dp_status_t status,
    output shtc_pkg::ctrl_cmd_t  cmd
);
    import shtc_pkg::*;

    typedef enum logic [2:0] {
        S_RUN  = 3'b001,
        S_DIV  = 3'b010,
        S_PEND = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign in_ready = state_reg == S_RUN;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next   = state_reg;
        cmd.step     = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            S_RUN:
            begin
                cmd.step = in_valid;
                if (in_valid && status.emit)
                begin
                    state_next = status.mean ? S_DIV : S_PEND;
                end
            end
            S_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = S_PEND;
                end
            end
            S_PEND:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_RUN;
                end
            end
            default:
            begin
                state_next = S_RUN;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RUN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
endmodule

/* src/surface_height_trace_chunker.sv */
// Pixels are taken one per cycle, column by column and bottom to top, and each
// column's surface height is traced as the pixels pass. When a column closes a
// chunk (or image_end arrives) the input pauses while the result is staged for
// highest/lowest mode, and for mean mode also while the bit-serial divider
// produces one quotient bit of the 21-bit chunk sum per cycle.
// A result waits in an output register while pixels keep flowing; the pause
// lengthens only if a second result is ready before the first is taken.
// Configuration is to be written over the APB port while the block is idle; the block does not enforce it.
module surface_height_trace_chunker (
    input  logic                            clk,
    input  logic                            rst_n,
    shtc_pix_if.sink                        pix,
    shtc_chunk_if.source                    chunk,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [shtc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [shtc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [shtc_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import shtc_pkg::*;

    cfg_t                 cfg_reg, cfg_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;
    ctrl_cmd_t            cmd;
    dp_status_t           status;

    assign pready  = 1'b1;
    assign reg_idx = paddr[REG_IDX_W+1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_CHUNK_SIZE:   cfg_next.chunk_size   = pwdata[CHUNK_W-1:0];
                REG_REDUCE_MODE:  cfg_next.reduce_mode  = pwdata[MODE_W-1:0];
                REG_CLEAR_COLOUR: cfg_next.clear_colour = pwdata[PIXEL_W-1:0];
                REG_IMAGE_HEIGHT: cfg_next.image_height = pwdata[HEIGHT_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_CHUNK_SIZE:   prdata = APB_DATA_W'(cfg_reg.chunk_size);
            REG_REDUCE_MODE:  prdata = APB_DATA_W'(cfg_reg.reduce_mode);
            REG_CLEAR_COLOUR: prdata = APB_DATA_W'(cfg_reg.clear_colour);
            REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(cfg_reg.image_height);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.chunk_size   <= CHUNK_W'(1);
            cfg_reg.reduce_mode  <= MODE_MEAN;
            cfg_reg.clear_colour <= '0;
            cfg_reg.image_height <= MAX_HEIGHT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    shtc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pix.valid),
        .in_ready  (pix.ready),
        .out_valid (chunk.valid),
        .out_ready (chunk.ready),
        .status    (status),
        .cmd       (cmd)
    );

    shtc_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .cmd          (cmd),
        .pixel_colour (pix.pixel_colour),
        .image_end    (pix.image_end),
        .status       (status),
        .chunk_height (chunk.chunk_height),
        .last_chunk   (chunk.last_chunk)
    );

    // no pixel taken while the divider works on a chunk sum
    a_no_step_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        status.div_busy |-> !pix.ready)
        else $error("pixel accepted during divide");

    // staged result moves only into a free output register
    a_load_into_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!chunk.valid || chunk.ready))
        else $error("output register overwritten");

    // a mean chunk starts the divider
    a_mean_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && status.emit && status.mean) |=> status.div_busy)
        else $error("divider not started");

    // reduced heights never exceed the largest image height, MAX_HEIGHT
    a_height_range: assert property (@(posedge clk) disable iff (!rst_n)
        chunk.valid |-> (chunk.chunk_height <= MAX_HEIGHT))
        else $error("chunk height out of range");
endmodule

/* sim/tb_surface_height_trace_chunker.sv */
// self-checking testbench for surface_height_trace_chunker: streams collision images, predicts
// every chunk height from its own column tracer and compares each accepted chunk result
// depends on shtc_pkg, shtc_if and the block itself
`timescale 1ns / 1ps

module tb_surface_height_trace_chunker;
    import shtc_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_PIXELS = 1900;
    localparam int BIG_ROWS      = 64;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [HEIGHT_W-1:0] height;
        logic                last_flag;
    } chunk_result_t;

    class height_chunk_board;
        logic [CHUNK_W-1:0]  chunk_size_r;
        logic [MODE_W-1:0]   mode_r;
        logic [PIXEL_W-1:0]  clear_r;
        logic [HEIGHT_W-1:0] height_r;

        logic [HEIGHT_W-1:0] traced;
        logic [ROW_W-1:0]    row;
        logic [HEIGHT_W-1:0] clear_above;
        logic [HEIGHT_W-1:0] run_bottom;
        logic                prev_clear;
        logic                found;
        logic [SUM_W-1:0]    sum;
        logic [HEIGHT_W-1:0] high;
        logic [HEIGHT_W-1:0] low;
        logic [CHUNK_W-1:0]  columns;

        chunk_result_t expected_chunks[$];
        int mismatches;

        function new();
            chunk_size_r = CHUNK_W'(1);
            mode_r       = MODE_MEAN;
            clear_r      = '0;
            height_r     = MAX_HEIGHT;
            traced       = '0;
            mismatches   = 0;
            start_column();
            start_chunk();
        endfunction

        function int unsigned effective_height();
            int unsigned h;
            h = height_r;
            if (h == 0)
                h = 1;
            if (h > MAX_HEIGHT)
                h = MAX_HEIGHT;
            return h;
        endfunction

        function int unsigned effective_chunk();
            int unsigned c;
            c = chunk_size_r;
            if (c == 0)
                c = 1;
            if (c > MAX_CHUNK)
                c = MAX_CHUNK;
            return c;
        endfunction

        function void start_column();
            row         = '0;
            clear_above = HEIGHT_W'(effective_height());
            run_bottom  = '0;
            prev_clear  = 1'b0;
            found       = 1'b0;
        endfunction

        function void start_chunk();
            sum     = '0;
            high    = '0;
            low     = '1;
            columns = '0;
        endfunction

        function void set_register(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] value);
            case (idx)
                REG_CHUNK_SIZE:   chunk_size_r = value[CHUNK_W-1:0];
                REG_REDUCE_MODE:  mode_r       = value[MODE_W-1:0];
                REG_CLEAR_COLOUR: clear_r      = value[PIXEL_W-1:0];
                REG_IMAGE_HEIGHT: height_r     = value[HEIGHT_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_pixel(logic [PIXEL_W-1:0] colour, logic image_end);
            int unsigned   rows;
            int unsigned   cs;
            int unsigned   r;
            int unsigned   h;
            int unsigned   colh;
            int unsigned   value;
            logic          is_clear;
            chunk_result_t res;

            rows     = effective_height();
            r        = row;
            h        = traced;
            is_clear = (colour == clear_r);

            if (is_clear && (r == 0 || !prev_clear))
                run_bottom = HEIGHT_W'(r);
            prev_clear = is_clear;

            // trace up to the first clear pixel, or down to the bottom of the clear run
            if (!found)
            begin
                if (r == h)
                begin
                    if (is_clear)
                    begin
                        clear_above = run_bottom;
                        found       = 1'b1;
                    end
                end
                else if (r > h && is_clear)
                begin
                    clear_above = HEIGHT_W'(r);
                    found       = 1'b1;
                end
            end

            if (!image_end && r + 1 < rows)
            begin
                row = ROW_W'(r + 1);
                return;
            end

            colh = found ? clear_above : rows;
            if (colh > rows)
                colh = rows;
            traced = HEIGHT_W'(colh);
            start_column();

            sum = sum + SUM_W'(colh);
            if (colh > high)
                high = HEIGHT_W'(colh);
            if (colh < low)
                low = HEIGHT_W'(colh);
            columns = columns + 1'b1;

            cs = effective_chunk();
            if (columns < cs && !image_end)
                return;

            // a partial last chunk still divides by the full chunk size
            case (mode_r)
                MODE_MEAN: value = int'(sum) / cs;
                MODE_HIGH: value = high;
                MODE_LOW:  value = low;
                default:   value = 0;
            endcase
            res.height    = HEIGHT_W'(value);
            res.last_flag = image_end;
            expected_chunks = {expected_chunks, res};

            start_chunk();
            if (image_end)
            begin
                traced = '0;
                start_column();
            end
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_chunk(logic [HEIGHT_W-1:0] height, logic last_flag);
            chunk_result_t want;
            if (expected_chunks.size() == 0)
            begin
                report_mismatch($sformatf("chunk height %0d last %0b with none pending",
                    height, last_flag));
                return;
            end
            want = expected_chunks.pop_front();
            if (height !== want.height)
                report_mismatch($sformatf("chunk_height %0d, want %0d", height, want.height));
            if (last_flag !== want.last_flag)
                report_mismatch($sformatf("last_chunk %0b, want %0b", last_flag,
                    want.last_flag));
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    shtc_pix_if   pix_bus();
    shtc_chunk_if chunk_bus();

    height_chunk_board board;
    bit                steady;
    int unsigned       cycle_count = 0;
    int unsigned       sent_pixels = 0;

    surface_height_trace_chunker u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix     (pix_bus),
        .chunk   (chunk_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic bit take_gap();
        return !steady && ($urandom_range(99) < 35);
    endfunction

    function automatic logic [PIXEL_W-1:0] solid_colour(logic [PIXEL_W-1:0] clear_c);
        logic [PIXEL_W-1:0] c;
        c = $urandom();
        if (c == clear_c)
            c = ~c;
        return c;
    endfunction

    always @(negedge clk)
        chunk_bus.ready = !take_gap();

    always @(posedge clk)
    begin
        if (rst_n && chunk_bus.valid && chunk_bus.ready)
            board.check_chunk(chunk_bus.chunk_height, chunk_bus.last_chunk);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        board.set_register(idx, value);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic configure(input logic [CHUNK_W-1:0] cs, input logic [MODE_W-1:0] mode,
                             input logic [PIXEL_W-1:0] clear_c, input logic [HEIGHT_W-1:0] rows);
        apb_write(REG_CHUNK_SIZE, APB_DATA_W'(cs));
        apb_write(REG_REDUCE_MODE, APB_DATA_W'(mode));
        apb_write(REG_CLEAR_COLOUR, clear_c);
        apb_write(REG_IMAGE_HEIGHT, APB_DATA_W'(rows));
    endtask

    task automatic push_pixel(input logic [PIXEL_W-1:0] colour, input logic image_end);
        @(negedge clk);
        while (take_gap())
        begin
            pix_bus.valid        = 1'b0;
            pix_bus.pixel_colour = $urandom();
            pix_bus.image_end    = 1'($urandom_range(1));
            @(negedge clk);
        end
        pix_bus.valid        = 1'b1;
        pix_bus.pixel_colour = colour;
        pix_bus.image_end    = image_end;
        @(posedge clk);
        while (!pix_bus.ready)
            @(posedge clk);
        board.note_pixel(colour, image_end);
        sent_pixels++;
    endtask

    task automatic park_pixels();
        @(negedge clk);
        pix_bus.valid = 1'b0;
    endtask

    task automatic drain();
        while (board.expected_chunks.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // columns drift around a surface with caves and overhangs; noisy columns are random
    task automatic send_landscape(input int rows, input int cols, input int cut,
                                  input logic [PIXEL_W-1:0] clear_c, input bit noisy);
        int   c;
        int   r;
        int   surface;
        int   last_row;
        logic want_clear;
        logic is_end;
        surface = $urandom_range(0, rows);
        for (c = 0; c < cols; c++)
        begin
            if ($urandom_range(3) == 0)
                surface = $urandom_range(0, rows);
            else
                surface = surface + int'($urandom_range(0, 4)) - 2;
            if (surface < 0)
                surface = 0;
            if (surface > rows)
                surface = rows;
            last_row = (c == cols - 1) ? cut : rows - 1;
            for (r = 0; r <= last_row; r++)
            begin
                if (noisy)
                    want_clear = 1'($urandom_range(1));
                else
                begin
                    want_clear = (r >= surface);
                    if ($urandom_range(11) == 0)
                        want_clear = !want_clear;
                end
                is_end = (c == cols - 1) && (r == last_row);
                push_pixel(want_clear ? clear_c : solid_colour(clear_c), is_end);
            end
        end
        park_pixels();
    endtask

    task automatic random_phase();
        logic [CHUNK_W-1:0]  cs;
        logic [MODE_W-1:0]   mode;
        logic [PIXEL_W-1:0]  clear_c;
        logic [HEIGHT_W-1:0] rows_reg;
        int                  pick;
        int                  rows;
        int                  cols;
        int                  cut;
        int                  cap;
        int                  n;

        pick = $urandom_range(99);
        if (pick < 70)
            cs = CHUNK_W'($urandom_range(1, 4));
        else if (pick < 85)
            cs = CHUNK_W'($urandom_range(5, 20));
        else if (pick < 93)
        begin
            case ($urandom_range(3))
                0: cs = '0;
                1: cs = CHUNK_W'(256);
                2: cs = CHUNK_W'(257);
                default: cs = '1;
            endcase
        end
        else
            cs = CHUNK_W'($urandom_range(0, 511));

        mode = ($urandom_range(9) == 0) ? MODE_UNUSED : MODE_W'($urandom_range(0, 2));

        pick = $urandom_range(9);
        if (pick == 0)
            clear_c = '0;
        else if (pick == 1)
            clear_c = '1;
        else
            clear_c = $urandom();

        pick = $urandom_range(99);
        if (pick < 70)
            rows_reg = HEIGHT_W'($urandom_range(1, 6));
        else if (pick < 90)
            rows_reg = HEIGHT_W'($urandom_range(7, 40));
        else if (pick < 95)
            rows_reg = '0;
        else
        begin
            case ($urandom_range(2))
                0: rows_reg = HEIGHT_W'(4096);
                1: rows_reg = '1;
                default: rows_reg = HEIGHT_W'($urandom_range(41, 8191));
            endcase
        end

        configure(cs, mode, clear_c, rows_reg);
        rows = board.effective_height();

        n = $urandom_range(1, 3);
        repeat (n)
        begin
            if (rows > BIG_ROWS)
            begin
                cols = 1;
                cut  = $urandom_range(0, 40);
            end
            else
            begin
                cap = 3 * board.effective_chunk() + 1;
                if (cap > 300 / rows)
                    cap = 300 / rows;
                if (cap < 1)
                    cap = 1;
                cols = $urandom_range(1, cap);
                cut  = ($urandom_range(3) == 0) ? $urandom_range(0, rows - 1) : rows - 1;
            end
            send_landscape(rows, cols, cut, clear_c, $urandom_range(7) == 0);
        end
        drain();
    endtask

    initial
    begin
        int unsigned target;
        int          phase;

        board                = new();
        steady               = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        pix_bus.valid        = 1'b0;
        pix_bus.pixel_colour = '0;
        pix_bus.image_end    = 1'b0;
        chunk_bus.ready      = 1'b0;
        rst_n                = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings, trace climbs from the first column, image end mid column
        push_pixel(32'hFFFF_FFFF, 1'b0);
        push_pixel(32'hFFFF_FFFF, 1'b0);
        push_pixel(32'h0000_0000, 1'b1);
        park_pixels();
        drain();

        // trace up, trace down to the run bottom, height beyond the column
        configure(CHUNK_W'(2), MODE_MEAN, 32'd5, HEIGHT_W'(4));
        push_pixel(32'd7, 1'b0);
        push_pixel(32'd7, 1'b0);
        push_pixel(32'd5, 1'b0);
        push_pixel(32'd7, 1'b0);
        push_pixel(32'd5, 1'b0);
        push_pixel(32'd5, 1'b0);
        push_pixel(32'd5, 1'b0);
        push_pixel(32'd7, 1'b0);
        repeat (4) push_pixel(32'd7, 1'b0);
        push_pixel(32'd5, 1'b0);
        push_pixel(32'd5, 1'b0);
        push_pixel(32'd5, 1'b1);
        park_pixels();
        drain();

        // oversized chunk and zero height, partial chunk divided by the full size
        configure('1, MODE_MEAN, 32'h0, '0);
        push_pixel(32'hFFFF_FFFF, 1'b0);
        push_pixel(32'h0000_0000, 1'b1);
        park_pixels();
        drain();

        // unused mode, then oversized image height with no clear pixel
        configure(CHUNK_W'(1), MODE_UNUSED, 32'hFFFF_FFFF, '1);
        push_pixel(32'hFFFF_FFFF, 1'b0);
        push_pixel(32'h0000_0000, 1'b1);
        park_pixels();
        drain();
        configure(CHUNK_W'(1), MODE_HIGH, 32'hFFFF_FFFF, '1);
        push_pixel(32'h0000_0000, 1'b1);
        park_pixels();
        drain();

        // lowest of a chunk closed by image end
        configure(CHUNK_W'(3), MODE_LOW, 32'h0, HEIGHT_W'(2));
        push_pixel(32'd1, 1'b0);
        push_pixel(32'd0, 1'b0);
        push_pixel(32'd1, 1'b0);
        push_pixel(32'd1, 1'b0);
        push_pixel(32'd0, 1'b1);
        park_pixels();
        drain();

        target = sent_pixels + RANDOM_PIXELS;
        phase  = 0;
        while (sent_pixels < target)
        begin
            steady = (phase >= 12 && phase < 22);
            random_phase();
            phase++;
        end
        steady = 1'b0;
        drain();

        if (board.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* filelist.f */
src/shtc_pkg.sv
src/shtc_if.sv
src/shtc_div.sv
src/shtc_datapath.sv
src/shtc_ctrl.sv
src/surface_height_trace_chunker.sv
sim/tb_surface_height_trace_chunker.sv
